[rtl/gco_pkg.sv]
// Shared types and fixed-point constants for the gingerbread-map chaos oscillator.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package gco_pkg;

  // Q8.24 unit and the output scale and offset (0.182 and 0.455 in Q.24)
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned RATE_W    = 23;
  localparam int unsigned PHASE_W   = 28;
  localparam int unsigned STEP_W    = 26;
  localparam int unsigned PROD_W    = 55;
  localparam int unsigned KSCALE_W  = 22;

  localparam logic [RATE_W-1:0]          RST_RATE  = 23'd89478;
  localparam logic signed [PHASE_W-1:0]  RST_PHASE = 28'sd16777216;
  localparam logic signed [31:0]         RST_NEWER = 32'sd20132659;
  localparam logic signed [31:0]         RST_OLDER = 32'sd35232154;
  localparam logic [KSCALE_W-1:0]        K_SCALE   = 22'd3053453;
  localparam logic signed [31:0]         K_OFFSET  = 32'sd7633633;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  // Beat as captured from the input channel
  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] freq;
    logic signed [31:0] seed_newer;
    logic signed [31:0] seed_older;
  } in_item_t;

  // After the frequency multiply
  typedef struct packed {
    opcode_t                   opcode;
    logic                      freq_neg;
    logic signed [PROD_W-1:0]  prod;
    logic signed [31:0]        seed_newer;
    logic signed [31:0]        seed_older;
  } prod_item_t;

  // After the phase and map update (ticks only)
  typedef struct packed {
    logic signed [31:0] map_newer;
    logic               stepped;
  } map_item_t;

endpackage

`default_nettype wire

[rtl/gco_mult.sv]
// Frequency multiply stage: freq times inv_rate, registered.
// Depends on gco_pkg.
`default_nettype none

module gco_mult (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [gco_pkg::RATE_W-1:0]    inv_rate,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire gco_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output gco_pkg::prod_item_t                out_item
);

  logic                 valid_r;
  gco_pkg::prod_item_t  item_r;
  gco_pkg::prod_item_t  item_nxt;
  logic signed [gco_pkg::PROD_W:0] prod_full;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // 32 x 24 signed multiply; the product fits in PROD_W bits
  always_comb begin
    prod_full               = in_item.freq * $signed({1'b0, inv_rate});
    item_nxt.opcode         = in_item.opcode;
    item_nxt.freq_neg       = in_item.freq[31];
    item_nxt.prod           = prod_full[gco_pkg::PROD_W-1:0];
    item_nxt.seed_newer     = in_item.seed_newer;
    item_nxt.seed_older     = in_item.seed_older;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/gco_core.sv]
// Phase accumulator with wrap detection and gingerbread-map state update.
// Depends on gco_pkg.
`default_nettype none

module gco_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire gco_pkg::prod_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output gco_pkg::map_item_t        out_item
);

  localparam logic signed [34:0] STEP_MAX = 35'sd16777216;
  localparam logic signed [34:0] STEP_MIN = -35'sd16777216;
  localparam logic signed [gco_pkg::PHASE_W-1:0] ONE_PH  = 28'sd16777216;
  localparam logic signed [gco_pkg::PHASE_W-1:0] ZERO_PH = 28'sd0;
  localparam logic signed [33:0] ONE_Y   = 34'sd16777216;
  localparam logic signed [33:0] Y_MAX   = 34'sd2147483647;
  localparam logic signed [33:0] Y_MIN   = -34'sd2147483648;

  logic                                  valid_r;
  gco_pkg::map_item_t                    item_r;
  gco_pkg::map_item_t                    item_nxt;
  logic signed [gco_pkg::PHASE_W-1:0]    phase_r;
  logic signed [gco_pkg::PHASE_W-1:0]    phase_nxt;
  logic signed [31:0]                    newer_r;
  logic signed [31:0]                    newer_nxt;
  logic signed [31:0]                    older_r;
  logic signed [31:0]                    older_nxt;

  logic signed [34:0]                    step_raw;
  logic signed [gco_pkg::STEP_W-1:0]     step;
  logic                                  trig;
  logic signed [gco_pkg::PHASE_W-1:0]    phase_wr;
  logic [31:0]                           newer_mag;
  logic signed [33:0]                    y_full;
  logic signed [31:0]                    y_sat;
  logic                                  accept;
  logic                                  is_tick;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;
  assign accept    = in_valid && in_ready;
  assign is_tick   = (in_item.opcode == gco_pkg::OP_TICK);

  // Step = floor(prod / 2^20), clipped to +-1.0
  always_comb begin
    step_raw = in_item.prod[gco_pkg::PROD_W-1:20];
    if (step_raw > STEP_MAX) begin
      step = STEP_MAX[gco_pkg::STEP_W-1:0];
    end else if (step_raw < STEP_MIN) begin
      step = STEP_MIN[gco_pkg::STEP_W-1:0];
    end else begin
      step = step_raw[gco_pkg::STEP_W-1:0];
    end
  end

  // Wrap test follows the sign of the current frequency
  always_comb begin
    if (!in_item.freq_neg) begin
      trig     = (phase_r >= ONE_PH);
      phase_wr = trig ? (phase_r - ONE_PH) : phase_r;
    end else begin
      trig     = (phase_r <= ZERO_PH);
      phase_wr = trig ? (phase_r + ONE_PH) : phase_r;
    end
  end

  // Map iteration y = 1 + |newer| - older, saturated to 32 bits
  always_comb begin
    newer_mag = newer_r[31] ? (~newer_r + 32'd1) : newer_r;
    y_full    = ONE_Y + $signed({2'b00, newer_mag}) - $signed({{2{older_r[31]}}, older_r});
    if (y_full > Y_MAX) begin
      y_sat = Y_MAX[31:0];
    end else if (y_full < Y_MIN) begin
      y_sat = Y_MIN[31:0];
    end else begin
      y_sat = y_full[31:0];
    end
  end

  // Next state per item kind
  always_comb begin
    phase_nxt = phase_r;
    newer_nxt = newer_r;
    older_nxt = older_r;
    if (!is_tick) begin
      newer_nxt = in_item.seed_newer;
      older_nxt = in_item.seed_older;
    end else begin
      phase_nxt = phase_wr + {{(gco_pkg::PHASE_W-gco_pkg::STEP_W){step[gco_pkg::STEP_W-1]}},
                              step};
      if (trig) begin
        newer_nxt = y_sat;
        older_nxt = newer_r;
      end
    end
    item_nxt.map_newer = newer_nxt;
    item_nxt.stepped   = is_tick && trig;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= gco_pkg::RST_PHASE;
      newer_r <= gco_pkg::RST_NEWER;
      older_r <= gco_pkg::RST_OLDER;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid && is_tick;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        newer_r <= newer_nxt;
        older_r <= older_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/gco_scale.sv]
// Output scaling: map value * 0.182 - 0.455 with rounding, into the result register.
// Depends on gco_pkg.
`default_nettype none

module gco_scale (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gco_pkg::map_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_sample,
  output logic                     out_stepped
);

  localparam logic signed [54:0] HALF = 55'sd8388608;

  logic               valid_r;
  logic signed [31:0] sample_r;
  logic signed [31:0] sample_nxt;
  logic               stepped_r;
  logic signed [54:0] prod;
  logic signed [54:0] rounded;
  logic signed [30:0] shifted;

  assign in_ready    = !valid_r || out_ready;
  assign out_valid   = valid_r;
  assign out_sample  = sample_r;
  assign out_stepped = stepped_r;

  // |shifted| < 2^29, so the offset subtract cannot leave the 32-bit range
  always_comb begin
    prod       = in_item.map_newer * $signed({1'b0, gco_pkg::K_SCALE});
    rounded    = prod + HALF;
    shifted    = rounded[54:gco_pkg::FRAC_W];
    sample_nxt = $signed({shifted[30], shifted}) - gco_pkg::K_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sample_r  <= sample_nxt;
      stepped_r <= in_item.stepped;
    end
  end

endmodule

`default_nettype wire

[rtl/gingerbread_chaos_oscillator.sv]
// Gingerbread-map chaos oscillator top level: input register and stage chain.
// Depends on gco_pkg, gco_mult, gco_core and gco_scale.
//
// Usage:
//   Input stream (in_*): one beat per item. in_tuser = 0 is a sample tick carrying
//   a signed Q20.12 frequency; in_tuser = 1 loads both map values (seed fields).
//   Output stream (out_*): one beat per tick: Q8.24 sample plus the stepped flag.
//   Loads produce no output beat.
//   Config (cfg_*): writes inv_rate (2^32 / sample rate); always ready. Write it
//   only while the block is idle.
// Timing:
//   Four register stages: input, multiply, phase/map update, result. A tick
//   accepted into the input register passes the multiply, phase/map update and
//   result registers before it shows on out_tvalid. Throughput is one item per
//   cycle while out_tready is high, set by gco_core's phase and map update loop.
// Reset (rst_n low, synchronous): phase 1.0, map values 1.2 and 2.1,
//   inv_rate 89478 (48 kHz), pipeline empty.
// Stall: when out_tready is low the stages fill up, bubbles are squeezed out,
//   and in_tready drops only once every stage holds a beat.
`default_nettype none

module gingerbread_chaos_oscillator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input stream
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [95:0]                  in_tdata,   // freq, seed_newer, seed_older
  input  wire logic                         in_tuser,   // opcode
  // Result stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [31:0]                       out_tdata,  // sample
  output logic                              out_tuser,  // stepped
  // Configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [gco_pkg::RATE_W-1:0]   cfg_data    // inv_rate
);

  logic                          in_valid_r;
  gco_pkg::in_item_t             in_item_r;
  gco_pkg::in_item_t             in_item_nxt;
  logic [gco_pkg::RATE_W-1:0]    inv_rate_r;

  logic                          mult_ready;
  logic                          mult_valid;
  gco_pkg::prod_item_t           mult_item;
  logic                          core_ready;
  logic                          core_valid;
  gco_pkg::map_item_t            core_item;
  logic                          scale_ready;
  logic signed [31:0]            sample;

  assign cfg_ready = 1'b1;
  assign in_tready = !in_valid_r || mult_ready;

  // Unpack the input beat
  always_comb begin
    in_item_nxt.opcode     = gco_pkg::opcode_t'(in_tuser);
    in_item_nxt.freq       = in_tdata[31:0];
    in_item_nxt.seed_newer = in_tdata[63:32];
    in_item_nxt.seed_older = in_tdata[95:64];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_rate_r <= gco_pkg::RST_RATE;
    end else if (cfg_valid && cfg_ready) begin
      inv_rate_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_item_nxt;
    end
  end

  gco_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .inv_rate  (inv_rate_r),
    .in_valid  (in_valid_r),
    .in_ready  (mult_ready),
    .in_item   (in_item_r),
    .out_valid (mult_valid),
    .out_ready (core_ready),
    .out_item  (mult_item)
  );

  gco_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mult_valid),
    .in_ready  (core_ready),
    .in_item   (mult_item),
    .out_valid (core_valid),
    .out_ready (scale_ready),
    .out_item  (core_item)
  );

  gco_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (core_valid),
    .in_ready    (scale_ready),
    .in_item     (core_item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sample  (sample),
    .out_stepped (out_tuser)
  );

  assign out_tdata = sample;

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for gingerbread_chaos_oscillator: a directed table of beats, then
// random phases under several inv_rate settings, idling patterns and one long output hold.
// Depends on gco_pkg and the block's RTL; reads no files.

module testbench;

  typedef logic [gco_pkg::RATE_W-1:0] rate_t;

  localparam longint UNIT_Q24     = 64'sd16777216;
  localparam longint SCALE_Q24    = longint'(gco_pkg::K_SCALE);
  localparam longint OFFSET_Q24   = longint'(gco_pkg::K_OFFSET);
  localparam int     MAX_REPORTS  = 10;
  localparam int     STALL_LIMIT  = 1000;
  localparam int     HOLD_CYCLES  = 64;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     N_DIRECTED   = 25;
  localparam int     N_PHASES     = 7;

  typedef enum {PACE_FULL, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  // One input beat; known_* holds a hand-computed result where one is typed in
  typedef struct {
    gco_pkg::opcode_t   opcode;
    logic signed [31:0] freq;
    logic signed [31:0] seed_newer;
    logic signed [31:0] seed_older;
    bit                 known;
    logic signed [31:0] known_sample;
    logic               known_stepped;
  } osc_beat_t;

  typedef struct {
    logic [31:0] sample;
    logic        stepped;
  } osc_result_t;

  typedef struct {
    rate_t             rate;
    bit                draw_rate;
    pace_t             pace;
    int                items;
    bit                squeeze;
  } run_phase_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  wire               in_tready;
  logic [95:0]       in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  wire               out_tvalid;
  logic              out_tready = 1'b0;
  wire  [31:0]       out_tdata;
  wire               out_tuser;
  logic              cfg_valid  = 1'b0;
  wire               cfg_ready;
  rate_t             cfg_data   = '0;

  // Oscillator state mirrored by the bench
  rate_t             osc_rate;
  int                osc_phase;
  int                osc_newer;
  int                osc_older;
  osc_result_t       expected_samples [$];

  int    fault_count  = 0;
  int    quiet_cycles = 0;
  pace_t pace         = PACE_FULL;
  bit    hold_pending = 1'b0;

  // Directed beats: reset state, extremes, sign changes, map overflow, loads
  osc_beat_t directed_beats [N_DIRECTED] = '{
    '{gco_pkg::OP_TICK, 32'sd0,       32'sd0,        32'sd0,        1'b1, -32'sd7328288, 1'b1},
    '{gco_pkg::OP_LOAD, 32'sd0,       32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'sd0,       32'sd0,        32'sd0,        1'b1, -32'sd7633633, 1'b0},
    '{gco_pkg::OP_TICK, -32'sd1,      32'sd0,        32'sd0,        1'b1, -32'sd4580180, 1'b1},
    '{gco_pkg::OP_TICK, 32'h7FFFFFFF, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h7FFFFFFF, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h80000000, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h80000000, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_LOAD, 32'hFFFFFFFF, 32'h80000000,  32'h80000000,  1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h7FFFFFFF, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h7FFFFFFF, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_LOAD, 32'sd0,       32'h7FFFFFFF,  32'h7FFFFFFF,  1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h80000000, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_LOAD, 32'sd0,       32'hFFFFFFFF,  32'h00000000,  1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'sd1,       32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, -32'sd1,      32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_LOAD, 32'sd0,       32'h55555555,  32'hAAAAAAAA,  1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h00400000, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'hFFC00000, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_LOAD, 32'sd0,       32'hAAAAAAAA,  32'h55555555,  1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h7FFFFFFF, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'hFFFFFFFF, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_LOAD, 32'sd0,       32'sd20132659, 32'sd35232154, 1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'h12345678, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0},
    '{gco_pkg::OP_TICK, 32'hEDCBA988, 32'sd0,        32'sd0,        1'b0, 32'sd0, 1'b0}
  };

  // Random phases: inv_rate setting, idling pattern, beat count, long output hold
  run_phase_t run_plan [N_PHASES] = '{
    '{23'd89478,   1'b0, PACE_FULL, 90, 1'b0},
    '{23'd1,       1'b0, PACE_SEND, 90, 1'b0},
    '{23'd4294967, 1'b0, PACE_RECV, 90, 1'b0},
    '{23'd0,       1'b0, PACE_BOTH, 70, 1'b0},
    '{23'd8388607, 1'b0, PACE_FULL, 90, 1'b1},
    '{23'd0,       1'b1, PACE_BOTH, 90, 1'b0},
    '{23'd89478,   1'b0, PACE_RECV, 80, 1'b0}
  };

  gingerbread_chaos_oscillator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // freq, seed_newer, seed_older
    .in_tuser   (in_tuser),    // opcode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // sample
    .out_tuser  (out_tuser),   // stepped
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // inv_rate
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void report_fault(string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Advance the mirrored oscillator by one accepted beat; queue the sample a tick makes
  function automatic void advance_oscillator(osc_beat_t b);
    longint      f;
    longint      step;
    longint      y;
    longint      s;
    osc_result_t r;
    if (b.opcode == gco_pkg::OP_LOAD) begin
      osc_newer = b.seed_newer;
      osc_older = b.seed_older;
      return;
    end
    f    = b.freq;
    step = (f * longint'(osc_rate)) >>> 20;
    if (step > UNIT_Q24) step = UNIT_Q24;
    if (step < -UNIT_Q24) step = -UNIT_Q24;
    // wrap test direction follows the sign of this tick's frequency
    if (f >= 0) begin
      r.stepped = (osc_phase >= UNIT_Q24);
      if (r.stepped) osc_phase = int'(osc_phase - UNIT_Q24);
    end else begin
      r.stepped = (osc_phase <= 0);
      if (r.stepped) osc_phase = int'(osc_phase + UNIT_Q24);
    end
    if (r.stepped) begin
      y = osc_newer;
      if (y < 0) y = -y;
      y = UNIT_Q24 + y - longint'(osc_older);
      osc_older = osc_newer;
      osc_newer = int'(sat32(y));
    end
    s = ((longint'(osc_newer) * SCALE_Q24 + UNIT_Q24 / 2) >>> 24) - OFFSET_Q24;
    r.sample  = 32'(sat32(s));
    osc_phase = int'(osc_phase + step);
    if (b.known) begin
      r.sample  = b.known_sample;
      r.stepped = b.known_stepped;
    end
    expected_samples.push_back(r);
  endfunction

  function automatic osc_beat_t random_beat();
    osc_beat_t   b;
    int unsigned mag;
    b.known         = 1'b0;
    b.known_sample  = '0;
    b.known_stepped = 1'b0;
    b.freq          = $urandom;
    b.seed_newer    = $urandom;
    b.seed_older    = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      b.opcode = gco_pkg::OP_LOAD;
      // most loads stay near the map's orbit (+-4.0), the rest land anywhere
      if ($urandom_range(0, 3) != 0) begin
        b.seed_newer = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        b.seed_older = int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      end
    end else begin
      b.opcode = gco_pkg::OP_TICK;
      // full range clips the step; smaller magnitudes give uneven wrap spacing
      case ($urandom_range(0, 2))
        0: mag = 0;
        1: mag = $urandom_range(0, 32'h0400_0000);
        default: mag = $urandom_range(0, 32'h0040_0000);
      endcase
      if (mag != 0) b.freq = $urandom_range(0, 1) ? -int'(mag) : int'(mag);
    end
    return b;
  endfunction

  function automatic bit sender_rests();
    case (pace)
      PACE_SEND: return $urandom_range(0, 99) < 56;
      PACE_BOTH: return $urandom_range(0, 99) < 34;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (pace)
      PACE_RECV: return $urandom_range(0, 99) < 56;
      PACE_BOTH: return $urandom_range(0, 99) < 34;
      default:   return 1'b0;
    endcase
  endfunction

  // Offer one beat, wait for the handshake, then update the mirror
  task automatic send_beat(osc_beat_t b);
    while (sender_rests()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b.opcode;
    in_tdata  <= {b.seed_older, b.seed_newer, b.freq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_oscillator(b);
  endtask

  // inv_rate changes only with the pipeline drained, loads included
  task automatic write_rate(rate_t v);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    osc_rate = v;
  endtask

  // Stimulus
  initial begin
    rate_t rate;
    osc_rate  = gco_pkg::RST_RATE;
    osc_phase = gco_pkg::RST_PHASE;
    osc_newer = gco_pkg::RST_NEWER;
    osc_older = gco_pkg::RST_OLDER;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_beats[i]) send_beat(directed_beats[i]);
    in_tvalid <= 1'b0;

    foreach (run_plan[p]) begin
      rate = run_plan[p].draw_rate ? rate_t'($urandom_range(1, 4294967)) : run_plan[p].rate;
      write_rate(rate);
      pace = run_plan[p].pace;
      for (int k = 0; k < run_plan[p].items; k++) begin
        if (run_plan[p].squeeze && k == 10) hold_pending = 1'b1;
        send_beat(random_beat());
      end
      in_tvalid <= 1'b0;
    end

    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("gingerbread_chaos_oscillator: match");
    end else begin
      $display("gingerbread_chaos_oscillator: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls per phase, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= !receiver_stalls();
      end
    end
  end

  // Compare each output beat with the oldest expected sample
  always @(posedge clk) begin
    osc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        report_fault($sformatf("unexpected beat: sample %h stepped %b", out_tdata, out_tuser));
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want.sample || out_tuser !== want.stepped)
          report_fault($sformatf("sample exp %h got %h, stepped exp %b got %b",
                                 want.sample, out_tdata, want.stepped, out_tuser));
      end
    end
  end

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("gingerbread_chaos_oscillator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[filelist.f]
rtl/gco_pkg.sv
rtl/gco_mult.sv
rtl/gco_core.sv
rtl/gco_scale.sv
rtl/gingerbread_chaos_oscillator.sv
dv/testbench.sv
